[src/erabu_pkg.sv]
package erabu_pkg;

    localparam int DATA_W       = 32;
    localparam int REG_NUM_W    = 3;
    localparam int IDX_W        = 10;
    localparam int NEXT_W       = 11;
    localparam int NUM_REGS_DEF = 8;
    localparam int PROG_DEPTH   = 1024;

    // wide enough for index plus one and for the end-of-program index
    localparam int NEXT_CALC_W  = ($clog2(PROG_DEPTH + 1) > NEXT_W) ?
                                  $clog2(PROG_DEPTH + 1) : NEXT_W;
    localparam logic [NEXT_CALC_W-1:0] PROG_DEPTH_C = NEXT_CALC_W'(PROG_DEPTH);

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_ADDI    = 4'd1,
        OP_SUB     = 4'd2,
        OP_MUL     = 4'd3,
        OP_DIV     = 4'd4,
        OP_B       = 4'd5,
        OP_BEQ     = 4'd6,
        OP_BNQ     = 4'd7,
        OP_END     = 4'd8,
        OP_PRELOAD = 4'd9
    } op_t;

    typedef struct packed {
        logic [3:0]              req_type;
        logic [REG_NUM_W-1:0]    dest;
        logic [REG_NUM_W-1:0]    src_a;
        logic [REG_NUM_W-1:0]    src_b;
        logic signed [DATA_W-1:0] immediate;
        logic [IDX_W-1:0]        target;
        logic [IDX_W-1:0]        index;
    } req_t;

    typedef struct packed {
        logic [NEXT_W-1:0]        next_index;
        logic                     branch_taken;
        logic                     halted;
        logic                     div_by_zero;
        logic signed [DATA_W-1:0] dest_value;
    } rsp_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              wr_en;
        logic              taken;
        logic              div_zero;
    } alu_res_t;

    typedef enum logic [1:0] {
        AL_IDLE,
        AL_DIV,
        AL_FIX
    } alu_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_D,
        ST_EXEC,
        ST_WAIT,
        ST_DONE
    } top_state_t;

endpackage

[src/eight_register_alu_branch_unit.sv]
// Executes one decoded instruction per item against a file of NUM_REGS 32-bit
// registers that read as zero after reset. Items are taken one at a time; a
// divide with a nonzero divisor takes longer than other items, as it runs the
// radix-2 divider that retires one quotient bit a cycle on the shared adder.
// Register reads go through one registered read port, so each item fetches
// both sources and the old destination value in turn. A finished result waits
// in the output register; the next item is accepted once the block is back in
// idle.
module eight_register_alu_branch_unit #(
    parameter int NUM_REGS = erabu_pkg::NUM_REGS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  erabu_pkg::req_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output erabu_pkg::rsp_t m_data
);
    import erabu_pkg::*;

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    top_state_t        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    logic              a_ok, b_ok, d_ok;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              rf_wr_en;
    logic              alu_start, alu_done;
    alu_res_t          alu_res;

    logic [NEXT_CALC_W-1:0] seq_idx, tgt_idx, next_calc;

    assign a_ok = 32'(req_reg.src_a) < 32'(NUM_REGS);
    assign b_ok = 32'(req_reg.src_b) < 32'(NUM_REGS);
    assign d_ok = 32'(req_reg.dest)  < 32'(NUM_REGS);

    always_comb begin
        case (state_reg)
            ST_RD_A: rd_addr = AW'(req_reg.src_a);
            ST_RD_B: rd_addr = AW'(req_reg.src_b);
            default: rd_addr = AW'(req_reg.dest);
        endcase
    end

    assign alu_start = (state_reg == ST_EXEC);
    assign rf_wr_en  = (state_reg == ST_WAIT) && alu_done && alu_res.wr_en && d_ok;

    erabu_regfile #(
        .NUM_REGS (NUM_REGS),
        .AW       (AW)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (rf_wr_en),
        .wr_addr (AW'(req_reg.dest)),
        .wr_data (alu_res.result),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    erabu_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .op      (req_reg.req_type),
        .a       (a_reg),
        .b       (b_reg),
        .imm     (req_reg.immediate),
        .done    (alu_done),
        .res     (alu_res)
    );

    // next instruction index
    always_comb begin
        seq_idx = NEXT_CALC_W'(req_reg.index) + NEXT_CALC_W'(1);
        if (seq_idx > PROG_DEPTH_C) begin
            seq_idx = PROG_DEPTH_C;
        end
        tgt_idx = NEXT_CALC_W'(req_reg.target);
        if (tgt_idx > PROG_DEPTH_C) begin
            tgt_idx = PROG_DEPTH_C;
        end
        if (req_reg.req_type == OP_END) begin
            next_calc = NEXT_CALC_W'(req_reg.index);
        end else if (alu_res.taken) begin
            next_calc = tgt_idx;
        end else begin
            next_calc = seq_idx;
        end
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        d_next       = d_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A: begin
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                a_next     = a_ok ? rd_data : '0;
                state_next = ST_RD_D;
            end
            ST_RD_D: begin
                b_next     = b_ok ? rd_data : '0;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                d_next     = d_ok ? rd_data : '0;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (alu_done) begin
                    if (rf_wr_en) begin
                        d_next = alu_res.result;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.next_index   = NEXT_W'(next_calc);
                    m_data_next.branch_taken = alu_res.taken;
                    m_data_next.halted       = (req_reg.req_type == OP_END);
                    m_data_next.div_by_zero  = alu_res.div_zero;
                    m_data_next.dest_value   = d_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        d_reg      <= d_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> state_reg == ST_WAIT)
        else $error("alu result arrived outside the wait state");

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_RD_A)
        else $error("accepted item did not start register reads");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && state_next == ST_IDLE) |=> m_valid_reg)
        else $error("finished item not presented on the result channel");
`endif

endmodule

[src/erabu_regfile.sv]
module erabu_regfile #(
    parameter int NUM_REGS = erabu_pkg::NUM_REGS_DEF,
    parameter int AW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [erabu_pkg::DATA_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [erabu_pkg::DATA_W-1:0] rd_data
);
    import erabu_pkg::*;

    logic [DATA_W-1:0]   mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [DATA_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    // an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[src/erabu_alu.sv]
module erabu_alu (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [3:0]                   op,
    input  logic [erabu_pkg::DATA_W-1:0] a,
    input  logic [erabu_pkg::DATA_W-1:0] b,
    input  logic [erabu_pkg::DATA_W-1:0] imm,
    output logic                         done,
    output erabu_pkg::alu_res_t          res
);
    import erabu_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    alu_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              negq_reg, negq_next;
    alu_res_t          res_reg, res_next;
    logic              done_reg, done_next;

    logic [DATA_W:0]   add_x, add_y, add_sum;
    logic              add_sub;
    logic [DATA_W-1:0] prod_lo, mag_a, mag_b;

    // shared adder: alu ops, branch compare, divide steps and sign fix
    always_comb begin
        add_x   = {1'b0, a};
        add_y   = {1'b0, b};
        add_sub = 1'b0;
        case (state_reg)
            AL_IDLE: begin
                if (op == OP_ADDI) begin
                    add_y = {1'b0, imm};
                end
                add_sub = (op == OP_SUB) || (op == OP_BEQ) || (op == OP_BNQ);
            end
            AL_DIV: begin
                add_x   = {rem_reg, quo_reg[DATA_W-1]};
                add_y   = {1'b0, dvs_reg};
                add_sub = 1'b1;
            end
            AL_FIX: begin
                add_x   = '0;
                add_y   = {1'b0, quo_reg};
                add_sub = negq_reg;
                if (!negq_reg) begin
                    add_x = {1'b0, quo_reg};
                    add_y = '0;
                end
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_x + (add_sub ? ~add_y : add_y) + (DATA_W + 1)'(add_sub);
    end

    assign prod_lo = a * b;
    assign mag_a   = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
    assign mag_b   = b[DATA_W-1] ? (DATA_W'(0) - b) : b;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        negq_next  = negq_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            AL_IDLE: begin
                if (start) begin
                    res_next  = '0;
                    done_next = 1'b1;
                    case (op)
                        OP_ADD, OP_ADDI, OP_SUB: begin
                            res_next.result = add_sum[DATA_W-1:0];
                            res_next.wr_en  = 1'b1;
                        end
                        OP_MUL: begin
                            res_next.result = prod_lo;
                            res_next.wr_en  = 1'b1;
                        end
                        OP_DIV: begin
                            if (b == '0) begin
                                res_next.div_zero = 1'b1;
                            end else begin
                                done_next  = 1'b0;
                                rem_next   = '0;
                                quo_next   = mag_a;
                                dvs_next   = mag_b;
                                negq_next  = a[DATA_W-1] ^ b[DATA_W-1];
                                cnt_next   = '0;
                                state_next = AL_DIV;
                            end
                        end
                        OP_B: begin
                            res_next.taken = 1'b1;
                        end
                        OP_BEQ: begin
                            res_next.taken = (add_sum[DATA_W-1:0] == '0);
                        end
                        OP_BNQ: begin
                            res_next.taken = (add_sum[DATA_W-1:0] != '0);
                        end
                        OP_PRELOAD: begin
                            res_next.result = imm;
                            res_next.wr_en  = 1'b1;
                        end
                        default: begin
                            res_next.wr_en = 1'b0;
                        end
                    endcase
                end
            end
            AL_DIV: begin
                // restoring step, one quotient bit a cycle
                if (!add_sum[DATA_W]) begin
                    rem_next = add_sum[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = add_x[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = AL_FIX;
                end
            end
            AL_FIX: begin
                res_next.result = add_sum[DATA_W-1:0];
                res_next.wr_en  = 1'b1;
                done_next       = 1'b1;
                state_next      = AL_IDLE;
            end
            default: begin
                state_next = AL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == AL_IDLE)
        else $error("alu started while busy");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == AL_DIV && cnt_reg == CNT_LAST) |=> state_reg == AL_FIX)
        else $error("divide did not finish after last step");

    a_done_src: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(state_reg) == AL_FIX || $past(start)))
        else $error("alu done without a start or fix step");
`endif

endmodule
